### hw/rtl/fat_chain_allocator_defines.svh
// assertion macros shared by the allocator modules
`ifndef FAT_CHAIN_ALLOCATOR_DEFINES_SVH
`define FAT_CHAIN_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define FCA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fca check failed");

// next-cycle implication
`define FCA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fca check failed");

// condition that must never be seen
`define FCA_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("fca check failed");

`endif

### hw/rtl/fca_pkg.sv
package fca_pkg;

   localparam int NUM_BLOCKS = 4096;
   localparam int BLK_W      = $clog2(NUM_BLOCKS);
   localparam int LINK_W     = BLK_W + 1;

   // table entry codes: link below NUM_BLOCKS, then end and free markers
   localparam logic [LINK_W-1:0] END_MARK  = LINK_W'(NUM_BLOCKS);
   localparam logic [LINK_W-1:0] FREE_MARK = LINK_W'(NUM_BLOCKS + 1);

   localparam logic [1:0] MODE_LOOKUP   = 2'd0;
   localparam logic [1:0] MODE_ALLOC    = 2'd1;
   localparam logic [1:0] MODE_TRUNCATE = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_PAST_END  = 2'd1;
   localparam logic [1:0] STATUS_DISK_FULL = 2'd2;

   typedef struct packed {
      logic       clr_wr;
      logic       accept;
      logic       head_chk;
      logic       trunc_zero;
      logic       cnt_one;
      logic       advance;
      logic       step_rd;
      logic       step_end;
      logic       step_chk;
      logic       set_status;
      logic [1:0] status_code;
      logic       set_disk;
      logic       scan_start;
      logic       scan_rd;
      logic       scan_inc;
      logic       al_end_wr;
      logic       al_link;
      logic       term_wr;
      logic       free_wr;
      logic       load_rsp;
   } fca_cmd_type;

   typedef struct packed {
      logic       clr_last;
      logic       rd_is_free;
      logic       cur_end;
      logic       ent_is_link;
      logic [1:0] mode;
      logic       cnt_eq_index;
      logic       cnt_lt_keep;
      logic       keep_zero;
      logic       scan_full;
   } fca_stat_type;

endpackage

### hw/rtl/fat_chain_allocator.sv
// File allocation table chain engine. The table holds one 13-bit entry per
// block (next block, end marker or free marker) in a single-port memory with
// a registered read. After reset the block runs a clearing pass, marking
// every entry free, and takes no request until it is done. One request is
// handled at a time; its result sits in an output register, so the next
// request is accepted while that result waits to be taken. Each request is
// accepted, its head checked and its result loaded; between those the
// sequencer walks the chain a link at a time (each link is one table read
// whose data is the next address). For each allocated block it starts the
// free scan at a lowest-free hint, reads table entries until one is free,
// then writes and links it. A truncate terminates the last kept block,
// reads past it and frees each block after it.
module fat_chain_allocator
   import fca_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_mode,
   input  logic [LINK_W-1:0] req_start_block,
   input  logic [BLK_W-1:0]  req_block_index,
   input  logic [LINK_W-1:0] req_keep_blocks,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BLK_W-1:0]  rsp_disk_block,
   output logic [LINK_W-1:0] rsp_head_block,
   output logic [1:0]        rsp_status,
   output logic [LINK_W-1:0] rsp_freed_count
);

   // command and status between sequencer and table datapath
   fca_cmd_type  cmd;
   fca_stat_type stat;

   // sequencer: clearing pass, chain walk, free scan, truncate
   fca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // table memory, walk registers, free hint and result register
   fca_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_mode        (req_mode),
      .req_start_block (req_start_block),
      .req_block_index (req_block_index),
      .req_keep_blocks (req_keep_blocks),
      .rsp_disk_block  (rsp_disk_block),
      .rsp_head_block  (rsp_head_block),
      .rsp_status      (rsp_status),
      .rsp_freed_count (rsp_freed_count)
   );

endmodule

### hw/rtl/fca_dpath.sv
`include "fat_chain_allocator_defines.svh"

module fca_dpath
   import fca_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  fca_cmd_type         cmd,
   output fca_stat_type        stat,
   input  logic [1:0]          req_mode,
   input  logic [LINK_W-1:0]   req_start_block,
   input  logic [BLK_W-1:0]    req_block_index,
   input  logic [LINK_W-1:0]   req_keep_blocks,
   output logic [BLK_W-1:0]    rsp_disk_block,
   output logic [LINK_W-1:0]   rsp_head_block,
   output logic [1:0]          rsp_status,
   output logic [LINK_W-1:0]   rsp_freed_count
);

   // chain table
   logic [LINK_W-1:0] mem [NUM_BLOCKS];
   logic              mem_we, mem_re;
   logic [BLK_W-1:0]  wr_addr, rd_addr;
   logic [LINK_W-1:0] wr_data;
   logic [LINK_W-1:0] rd_ff;

   // control registers
   logic [BLK_W-1:0]  clr_ff, clr_in;
   logic [LINK_W-1:0] hint_ff, hint_in;

   // working registers
   logic [1:0]        mode_ff, mode_in;
   logic [LINK_W-1:0] start_ff, start_in;
   logic [BLK_W-1:0]  index_ff, index_in;
   logic [LINK_W-1:0] keep_ff, keep_in;
   logic [LINK_W-1:0] head_ff, head_in;
   logic [BLK_W-1:0]  cur_ff, cur_in;
   logic [LINK_W-1:0] ent_ff, ent_in;
   logic              cur_end_ff, cur_end_in;
   logic [BLK_W-1:0]  prev_ff, prev_in;
   logic              prev_end_ff, prev_end_in;
   logic [LINK_W-1:0] cnt_ff, cnt_in;
   logic [LINK_W-1:0] scan_ff, scan_in;
   logic [BLK_W-1:0]  disk_ff, disk_in;
   logic [1:0]        status_ff, status_in;
   logic [LINK_W-1:0] freed_ff, freed_in;

   // result register
   logic [BLK_W-1:0]  out_disk_ff, out_disk_in;
   logic [LINK_W-1:0] out_head_ff, out_head_in;
   logic [1:0]        out_status_ff, out_status_in;
   logic [LINK_W-1:0] out_freed_ff, out_freed_in;

   logic rd_is_free;
   logic start_is_block;

   assign rd_is_free     = (rd_ff == FREE_MARK);
   assign start_is_block = (start_ff < END_MARK);

   always_comb begin
      mem_we  = 1'b0;
      wr_addr = clr_ff;
      wr_data = FREE_MARK;
      if (cmd.clr_wr) begin
         mem_we = 1'b1;
      end
      if (cmd.al_end_wr) begin
         mem_we  = 1'b1;
         wr_addr = scan_ff[BLK_W-1:0];
         wr_data = END_MARK;
      end
      if (cmd.al_link && !prev_end_ff) begin
         mem_we  = 1'b1;
         wr_addr = prev_ff;
         wr_data = scan_ff;
      end
      if (cmd.term_wr) begin
         mem_we  = 1'b1;
         wr_addr = cur_ff;
         wr_data = END_MARK;
      end
      if (cmd.free_wr) begin
         mem_we  = 1'b1;
         wr_addr = cur_ff;
         wr_data = FREE_MARK;
      end
   end

   always_comb begin
      mem_re  = cmd.accept | cmd.step_rd | cmd.scan_rd;
      rd_addr = req_start_block[BLK_W-1:0];
      if (cmd.step_rd) begin
         rd_addr = ent_ff[BLK_W-1:0];
      end
      if (cmd.scan_rd) begin
         rd_addr = scan_ff[BLK_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      clr_in        = clr_ff;
      hint_in       = hint_ff;
      mode_in       = mode_ff;
      start_in      = start_ff;
      index_in      = index_ff;
      keep_in       = keep_ff;
      head_in       = head_ff;
      cur_in        = cur_ff;
      ent_in        = ent_ff;
      cur_end_in    = cur_end_ff;
      prev_in       = prev_ff;
      prev_end_in   = prev_end_ff;
      cnt_in        = cnt_ff;
      scan_in       = scan_ff;
      disk_in       = disk_ff;
      status_in     = status_ff;
      freed_in      = freed_ff;
      out_disk_in   = out_disk_ff;
      out_head_in   = out_head_ff;
      out_status_in = out_status_ff;
      out_freed_in  = out_freed_ff;

      if (cmd.clr_wr) begin
         clr_in = clr_ff + BLK_W'(1);
      end
      if (cmd.accept) begin
         mode_in     = req_mode;
         start_in    = req_start_block;
         index_in    = req_block_index;
         keep_in     = req_keep_blocks;
         head_in     = END_MARK;
         cur_end_in  = 1'b1;
         prev_end_in = 1'b1;
         cnt_in      = '0;
         disk_in     = '0;
         status_in   = STATUS_OK;
         freed_in    = '0;
      end
      // head is a member only if it names a block that is not free
      if (cmd.head_chk && start_is_block && !rd_is_free) begin
         head_in    = start_ff;
         cur_in     = start_ff[BLK_W-1:0];
         ent_in     = rd_ff;
         cur_end_in = 1'b0;
      end
      if (cmd.trunc_zero) begin
         head_in = END_MARK;
      end
      if (cmd.cnt_one) begin
         cnt_in = LINK_W'(1);
      end
      if (cmd.advance) begin
         prev_in     = cur_ff;
         prev_end_in = 1'b0;
         cnt_in      = cnt_ff + LINK_W'(1);
      end
      if (cmd.step_end) begin
         cur_end_in = 1'b1;
      end
      if (cmd.step_chk) begin
         if (rd_is_free) begin
            cur_end_in = 1'b1;
         end else begin
            cur_in = ent_ff[BLK_W-1:0];
            ent_in = rd_ff;
         end
      end
      if (cmd.set_status) begin
         status_in = cmd.status_code;
      end
      if (cmd.set_disk) begin
         disk_in = cur_ff;
      end
      if (cmd.scan_start) begin
         scan_in = hint_ff;
      end
      // every block below the hint is in use
      if (cmd.scan_inc) begin
         scan_in = scan_ff + LINK_W'(1);
         hint_in = scan_ff + LINK_W'(1);
      end
      if (cmd.al_link) begin
         if (prev_end_ff) begin
            head_in = scan_ff;
         end
         cur_in     = scan_ff[BLK_W-1:0];
         ent_in     = END_MARK;
         cur_end_in = 1'b0;
         hint_in    = scan_ff + LINK_W'(1);
      end
      if (cmd.free_wr) begin
         freed_in = freed_ff + LINK_W'(1);
         if ({1'b0, cur_ff} < hint_ff) begin
            hint_in = {1'b0, cur_ff};
         end
      end
      if (cmd.load_rsp) begin
         out_disk_in   = disk_ff;
         out_head_in   = head_ff;
         out_status_in = status_ff;
         out_freed_in  = freed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         hint_ff <= '0;
      end else begin
         clr_ff  <= clr_in;
         hint_ff <= hint_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      start_ff      <= start_in;
      index_ff      <= index_in;
      keep_ff       <= keep_in;
      head_ff       <= head_in;
      cur_ff        <= cur_in;
      ent_ff        <= ent_in;
      cur_end_ff    <= cur_end_in;
      prev_ff       <= prev_in;
      prev_end_ff   <= prev_end_in;
      cnt_ff        <= cnt_in;
      scan_ff       <= scan_in;
      disk_ff       <= disk_in;
      status_ff     <= status_in;
      freed_ff      <= freed_in;
      out_disk_ff   <= out_disk_in;
      out_head_ff   <= out_head_in;
      out_status_ff <= out_status_in;
      out_freed_ff  <= out_freed_in;
   end

   always_comb begin
      stat.clr_last     = (clr_ff == BLK_W'(NUM_BLOCKS - 1));
      stat.rd_is_free   = rd_is_free;
      stat.cur_end      = cur_end_ff;
      stat.ent_is_link  = (ent_ff < END_MARK);
      stat.mode         = mode_ff;
      stat.cnt_eq_index = (cnt_ff == {1'b0, index_ff});
      stat.cnt_lt_keep  = (cnt_ff < keep_ff);
      stat.keep_zero    = (keep_ff == '0);
      stat.scan_full    = (scan_ff == END_MARK);
   end

   assign rsp_disk_block  = out_disk_ff;
   assign rsp_head_block  = out_head_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_freed_count = out_freed_ff;

   `FCA_ASSERT_NEVER(a_rw_apart, clock, reset, mem_we && mem_re)
   `FCA_ASSERT_IMPL(a_hint_range, clock, reset, 1'b1, hint_ff <= END_MARK)
   `FCA_ASSERT_IMPL(a_cur_live, clock, reset, cmd.term_wr || cmd.free_wr || cmd.set_disk, !cur_end_ff)

endmodule

### hw/rtl/fca_ctrl.sv
`include "fat_chain_allocator_defines.svh"

module fca_ctrl
   import fca_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output fca_cmd_type  cmd,
   input  fca_stat_type stat
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HEAD,
      ST_LOOK,
      ST_STEP,
      ST_STEP_CHK,
      ST_SCAN,
      ST_SCAN_CHK,
      ST_AL_END,
      ST_AL_LINK,
      ST_TRUNC,
      ST_TERM,
      ST_FREE,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (stat.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_HEAD;
            end
         end
         ST_HEAD: begin
            cmd.head_chk = 1'b1;
            case (stat.mode)
               MODE_LOOKUP, MODE_ALLOC: begin
                  state_in = ST_LOOK;
               end
               MODE_TRUNCATE: begin
                  if (stat.keep_zero) begin
                     cmd.trunc_zero = 1'b1;
                     state_in       = ST_FREE;
                  end else begin
                     cmd.cnt_one = 1'b1;
                     state_in    = ST_TRUNC;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_LOOK: begin
            if (stat.cur_end) begin
               if (stat.mode == MODE_LOOKUP) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = STATUS_PAST_END;
                  state_in        = ST_DONE;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end
            end else if (stat.cnt_eq_index) begin
               cmd.set_disk = 1'b1;
               state_in     = ST_DONE;
            end else begin
               cmd.advance = 1'b1;
               ret_in      = ST_LOOK;
               state_in    = ST_STEP;
            end
         end
         ST_STEP: begin
            if (stat.ent_is_link) begin
               cmd.step_rd = 1'b1;
               state_in    = ST_STEP_CHK;
            end else begin
               cmd.step_end = 1'b1;
               state_in     = ret_ff;
            end
         end
         ST_STEP_CHK: begin
            cmd.step_chk = 1'b1;
            state_in     = ret_ff;
         end
         ST_SCAN: begin
            if (stat.scan_full) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STATUS_DISK_FULL;
               state_in        = ST_DONE;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (stat.rd_is_free) begin
               state_in = ST_AL_END;
            end else begin
               cmd.scan_inc = 1'b1;
               state_in     = ST_SCAN;
            end
         end
         ST_AL_END: begin
            cmd.al_end_wr = 1'b1;
            state_in      = ST_AL_LINK;
         end
         ST_AL_LINK: begin
            cmd.al_link = 1'b1;
            state_in    = ST_LOOK;
         end
         ST_TRUNC: begin
            if (stat.cnt_lt_keep && !stat.cur_end) begin
               cmd.advance = 1'b1;
               ret_in      = ST_TRUNC;
               state_in    = ST_STEP;
            end else if (!stat.cur_end) begin
               state_in = ST_TERM;
            end else begin
               state_in = ST_FREE;
            end
         end
         ST_TERM: begin
            cmd.term_wr = 1'b1;
            ret_in      = ST_FREE;
            state_in    = ST_STEP;
         end
         ST_FREE: begin
            if (stat.cur_end) begin
               state_in = ST_DONE;
            end else begin
               cmd.free_wr = 1'b1;
               ret_in      = ST_FREE;
               state_in    = ST_STEP;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ret_ff       <= ST_LOOK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `FCA_ASSERT_NEXT(a_rsp_held, clock, reset, state_ff == ST_DONE && rsp_valid_ff && !rsp_ready, state_ff == ST_DONE)

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import fca_pkg::*;

   typedef struct packed {
      logic [BLK_W-1:0]  disk_block;
      logic [LINK_W-1:0] head_block;
      logic [1:0]        status;
      logic [LINK_W-1:0] freed_count;
   } fat_result_type;

   localparam int NUM_FILES = 8;
   localparam int RANDOM_REQUESTS = 1150;
   localparam logic [1:0] MODE_UNKNOWN = 2'd3;

   // mirror of the allocation table plus the queue of responses still owed
   class fat_table_mirror;
      logic [LINK_W-1:0] link_of [NUM_BLOCKS];
      int unsigned       free_hint;
      fat_result_type    awaited[$];
      int                mismatches;

      function new();
         foreach (link_of[b]) link_of[b] = FREE_MARK;
         free_hint  = 0;
         mismatches = 0;
      endfunction

      function bit is_member(int unsigned b);
         if (b >= NUM_BLOCKS) return 1'b0;
         return link_of[b] != FREE_MARK;
      endfunction

      function int unsigned follow(int unsigned b);
         int unsigned nx;
         nx = link_of[b];
         return is_member(nx) ? nx : NUM_BLOCKS;
      endfunction

      function int unsigned lowest_free();
         int unsigned b;
         for (b = free_hint; b < NUM_BLOCKS; b++) begin
            if (link_of[b] == FREE_MARK) begin
               free_hint = b;
               return b;
            end
         end
         free_hint = NUM_BLOCKS;
         return NUM_BLOCKS;
      endfunction

      function fat_result_type note_request(logic [1:0] mode, logic [LINK_W-1:0] start,
                                            logic [BLK_W-1:0] idx, logic [LINK_W-1:0] keep);
         int unsigned    head, cur, prev, step, nb, raw, disk, freed;
         logic [1:0]     status;
         bit             done;
         fat_result_type res;
         head   = is_member(start) ? start : NUM_BLOCKS;
         disk   = 0;
         freed  = 0;
         status = STATUS_OK;
         if (mode == MODE_LOOKUP || mode == MODE_ALLOC) begin
            cur  = head;
            prev = NUM_BLOCKS;
            step = 0;
            done = 1'b0;
            while (!done) begin
               if (cur == NUM_BLOCKS) begin
                  if (mode == MODE_LOOKUP) begin
                     status = STATUS_PAST_END;
                     done   = 1'b1;
                  end else begin
                     nb = lowest_free();
                     if (nb == NUM_BLOCKS) begin
                        status = STATUS_DISK_FULL;
                        done   = 1'b1;
                     end else begin
                        link_of[nb] = END_MARK;
                        if (prev == NUM_BLOCKS) head = nb;
                        else link_of[prev] = LINK_W'(nb);
                        cur = nb;
                     end
                  end
               end
               if (!done) begin
                  if (step == idx) begin
                     disk = cur;
                     done = 1'b1;
                  end else begin
                     prev = cur;
                     cur  = follow(cur);
                     step++;
                  end
               end
            end
            if (status != STATUS_OK) disk = 0;
         end else if (mode == MODE_TRUNCATE) begin
            cur = head;
            if (keep == 0) begin
               head = NUM_BLOCKS;
            end else begin
               for (step = 1; step < keep && cur != NUM_BLOCKS; step++) cur = follow(cur);
               if (cur != NUM_BLOCKS) begin
                  raw          = link_of[cur];
                  link_of[cur] = END_MARK;
                  cur          = is_member(raw) ? raw : NUM_BLOCKS;
               end
            end
            // release the tail, stopping at anything already free
            while (cur != NUM_BLOCKS) begin
               raw          = link_of[cur];
               link_of[cur] = FREE_MARK;
               if (cur < free_hint) free_hint = cur;
               freed++;
               cur = is_member(raw) ? raw : NUM_BLOCKS;
            end
         end
         res.disk_block  = BLK_W'(disk);
         res.head_block  = LINK_W'(head);
         res.status      = status;
         res.freed_count = LINK_W'(freed);
         awaited.push_back(res);
         return res;
      endfunction

      function void check_response(fat_result_type got);
         fat_result_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: disk %0d head %0d status %0d freed %0d",
                        got.disk_block, got.head_block, got.status, got.freed_count);
            return;
         end
         want = awaited.pop_front();
         if (got.disk_block != want.disk_block || got.head_block != want.head_block ||
             got.status != want.status || got.freed_count != want.freed_count) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response error at %0t: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                        $time,
                        want.disk_block, want.head_block, want.status, want.freed_count,
                        got.disk_block, got.head_block, got.status, got.freed_count);
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_mode = MODE_LOOKUP;
   logic [LINK_W-1:0] req_start_block = '0;
   logic [BLK_W-1:0]  req_block_index = '0;
   logic [LINK_W-1:0] req_keep_blocks = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [BLK_W-1:0]  rsp_disk_block;
   logic [LINK_W-1:0] rsp_head_block;
   logic [1:0]        rsp_status;
   logic [LINK_W-1:0] rsp_freed_count;

   fat_table_mirror book = new();

   // heads of the files the random part keeps working on
   logic [LINK_W-1:0] file_head [NUM_FILES];
   int                burst_left = 0;

   always #5 clock = ~clock;

   fat_chain_allocator i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_start_block (req_start_block),
      .req_block_index (req_block_index),
      .req_keep_blocks (req_keep_blocks),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_disk_block  (rsp_disk_block),
      .rsp_head_block  (rsp_head_block),
      .rsp_status      (rsp_status),
      .rsp_freed_count (rsp_freed_count)
   );

   // offer one request and hold it until the block takes it; valid stays high
   task automatic send_request(input logic [1:0] mode, input logic [LINK_W-1:0] start,
                               input logic [BLK_W-1:0] idx, input logic [LINK_W-1:0] keep,
                               output fat_result_type res);
      req_mode        <= mode;
      req_start_block <= start;
      req_block_index <= idx;
      req_keep_blocks <= keep;
      req_valid       <= 1'b1;
      do @(posedge clock); while (!req_ready);
      res = book.note_request(mode, start, idx, keep);
   endtask

   // burst pacing: called right after an acceptance
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         // now and then a long burst with no gaps at all
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(0, 20);
      end
   endtask

   // stop offering until every owed response has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (book.pending() > 0) @(posedge clock);
   endtask

   // response side: check each accepted response, stall on a pattern of its own
   initial begin
      int received;
      bit held;
      int phase_left;
      int style;
      received   = 0;
      held       = 1'b0;
      phase_left = 0;
      style      = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            book.check_response({rsp_disk_block, rsp_head_block, rsp_status,
                                 rsp_freed_count});
            received++;
         end
         if (received >= 300 && !held) begin
            // long hold-off so the block backs up and stalls its input
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (500) @(posedge clock);
         end else begin
            if (phase_left == 0) begin
               style      = $urandom_range(0, 3);
               phase_left = $urandom_range(20, 200);
            end
            phase_left--;
            case (style)
               0: begin
                  rsp_ready <= 1'b1;
               end
               1: begin
                  rsp_ready <= ($urandom_range(0, 3) != 0);
               end
               2: begin
                  rsp_ready <= ($urandom_range(0, 3) == 0);
               end
               default: begin
                  rsp_ready <= ~rsp_ready;
               end
            endcase
         end
      end
   end

   // stimulus
   initial begin
      fat_result_type    res;
      logic [LINK_W-1:0] file_a, file_b, big;
      logic [1:0]        mode;
      logic [LINK_W-1:0] start, keep;
      logic [BLK_W-1:0]  idx;
      int slot, pick, n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed part
      send_request(MODE_LOOKUP, END_MARK, 0, 0, res); pace();         // empty file
      send_request(MODE_ALLOC, END_MARK, 3, 0, res); pace();          // new file, 4 blocks
      file_a = res.head_block;
      send_request(MODE_LOOKUP, file_a, 2, 0, res); pace();
      send_request(MODE_LOOKUP, file_a, 4, 0, res); pace();           // past end
      send_request(MODE_ALLOC, END_MARK, 1, 0, res); pace();
      file_b = res.head_block;
      // cut the first file from its third block, leaving a stale link behind
      send_request(MODE_TRUNCATE, 2, 0, 0, res); pace();
      send_request(MODE_LOOKUP, file_a, 3, 0, res); pace();
      send_request(MODE_ALLOC, file_a, 2, 0, res); pace();            // re-grow over stale link
      send_request(MODE_TRUNCATE, file_a, 0, 2, res); pace();
      send_request(MODE_TRUNCATE, file_a, 0, 5, res); pace();         // keep beyond length
      send_request(MODE_ALLOC, file_b, 4, 0, res); pace();
      send_request(MODE_UNKNOWN, file_b, 4095, 8191, res); pace();    // unknown mode
      send_request(MODE_LOOKUP, FREE_MARK, 0, 0, res); pace();        // head out of range
      send_request(MODE_LOOKUP, 8191, 4095, 8191, res); pace();
      send_request(MODE_LOOKUP, 100, 0, 0, res); pace();              // head on a free block
      send_request(MODE_TRUNCATE, file_b, 0, 0, res); pace();         // delete
      send_request(MODE_TRUNCATE, END_MARK, 0, 0, res); pace();
      send_request(MODE_TRUNCATE, 8191, 0, 8191, res); pace();
      // fill the whole disk, then ask for one more block
      send_request(MODE_ALLOC, END_MARK, 4095, 0, res); pace();
      big = res.head_block;
      send_request(MODE_ALLOC, END_MARK, 0, 0, res); pace();
      send_request(MODE_LOOKUP, big, 4095, 0, res); pace();
      send_request(MODE_LOOKUP, file_a, 1, 0, res); pace();
      send_request(MODE_TRUNCATE, big, 0, 4096, res); pace();
      send_request(MODE_TRUNCATE, big, 0, 1, res); pace();
      send_request(MODE_TRUNCATE, big, 0, 0, res); pace();

      foreach (file_head[f]) file_head[f] = END_MARK;
      file_head[0] = file_a;

      // random part: mostly coherent work on a few files, some noise
      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         pick = $urandom_range(0, 99);
         slot = $urandom_range(0, NUM_FILES - 1);
         start = file_head[slot];
         idx   = '0;
         keep  = LINK_W'($urandom_range(0, 8191));
         if (pick < 35) begin
            mode = MODE_ALLOC;
            idx  = BLK_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                      : $urandom_range(0, 15));
         end else if (pick < 65) begin
            mode = MODE_LOOKUP;
            idx  = BLK_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                      : $urandom_range(0, 20));
         end else if (pick < 85) begin
            mode = MODE_TRUNCATE;
            idx  = BLK_W'($urandom_range(0, 4095));
            case ($urandom_range(0, 9))
               0: keep = '0;
               1: keep = LINK_W'($urandom_range(0, 8191));
               default: keep = LINK_W'($urandom_range(1, 24));
            endcase
         end else begin
            mode = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 1) == 0) start = LINK_W'($urandom_range(0, 8191));
            idx  = BLK_W'((mode == MODE_ALLOC) ? $urandom_range(0, 15)
                                               : $urandom_range(0, 4095));
         end
         send_request(mode, start, idx, keep, res);
         if (pick < 85) file_head[slot] = res.head_block;
         if (n == 600) drain();
         else pace();
      end

      drain();
      repeat (200) @(posedge clock);
      if (book.mismatches == 0 && book.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // watchdog
   initial begin
      #200_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
